[hw/rtl/sample_frame_serializer_crc16_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the sample frame serializer
// Shared same-cycle and next-cycle implication property shorthands.
// ----------------------------------------------------------------------------
`ifndef SAMPLE_FRAME_SERIALIZER_CRC16_MACROS_SVH
`define SAMPLE_FRAME_SERIALIZER_CRC16_MACROS_SVH

// same-cycle implication, disabled during reset
`define SFSC_ASSERT_IMPL(name, clk_i, rstn_i, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define SFSC_ASSERT_NEXT(name, clk_i, rstn_i, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/sfsc_pkg.sv]
// ----------------------------------------------------------------------------
// sfsc_pkg
// Types, constants and the CRC byte update shared by the serializer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package sfsc_pkg;

  localparam int unsigned IN_TDATA_W  = 152;
  localparam int unsigned LEN_W       = 9;
  localparam int unsigned IDX_W       = 5;
  localparam int unsigned MAX_PAYLOAD = 384;

  localparam logic CMD_HEADER  = 1'b0;
  localparam logic CMD_PAYLOAD = 1'b1;

  localparam logic [15:0] CRC_INIT       = 16'hFFFF;
  localparam logic [15:0] CRC_POLY       = 16'h1021;
  localparam logic [15:0] FIXED_OVERHEAD = 16'd28;

  localparam logic [7:0] MAGIC_0     = 8'h43;  // 'C'
  localparam logic [7:0] MAGIC_1     = 8'h53;  // 'S'
  localparam logic [7:0] MAGIC_2     = 8'h49;  // 'I'
  localparam logic [7:0] MAGIC_3     = 8'h32;  // '2'
  localparam logic [7:0] VERSION     = 8'd1;
  localparam logic [7:0] SAMPLE_KIND = 8'd1;

  // header byte positions
  localparam logic [IDX_W-1:0] IDX_CRC_FIRST = 5'd4;
  localparam logic [IDX_W-1:0] IDX_HEAD_LAST = 5'd25;

  typedef struct packed {
    logic              cmd;
    logic              last;
    logic [31:0]       seq;
    logic [63:0]       ts;
    logic signed [7:0] rssi;
    logic [7:0]        rate;
    logic [7:0]        channel;
    logic [7:0]        flags;
    logic [LEN_W-1:0]  len;
    logic [7:0]        pbyte;
  } sfsc_entry_t;

  typedef struct packed {
    logic        valid;
    sfsc_entry_t entry;
  } sfsc_push_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HEAD,
    ST_CRC_LO,
    ST_CRC_HI
  } sfsc_state_t;

  // CRC-16/CCITT-FALSE, one byte, msb first
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/sample_frame_serializer_crc16.sv]
// Sample frame serializer with CRC-16/CCITT-FALSE trailer.
// Input channel (in_*): one beat per item. in_tuser = 0 is a header that
// opens a frame; in_tuser = 1 carries one payload byte of the open frame.
// Headers with a length above the maximum payload, and payload beats with no
// frame open, are dropped and emit nothing; a new header abandons an open
// frame without a CRC.
// Output channel (out_*): one frame byte per beat. out_tlast marks the last
// byte caused by an input beat, out_tuser the CRC high byte ending a frame.
// A header produces 26 output bytes (28 with an empty payload), a payload
// byte one, the last payload byte three (byte and two CRC bytes).
// The output register moves one byte per cycle while out_tready is high,
// which sets the rate. Input beats pass the queue, then the output register.
// A queue of QUEUE_DEPTH items decouples input from the serializer, so input
// keeps flowing while out_tready is low until the queue fills.
// Reset (rst_n low, synchronous) empties the queue, closes any frame and
// drops a byte held at the output.
// ----------------------------------------------------------------------------
// sample_frame_serializer_crc16
// Top level: front classifier, item queue and byte serializer.
// ----------------------------------------------------------------------------
`default_nettype none

module sample_frame_serializer_crc16 import sfsc_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // seq[31:0], ts[95:32], rssi[103:96], rate[111:104], channel[119:112],
  // flags[127:120], payload_length[136:128], payload_byte[144:137], zeros
  input  wire logic [IN_TDATA_W-1:0] in_tdata,
  input  wire logic                  in_tuser,   // cmd
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [7:0]                 out_tdata,  // out_byte[7:0]
  output logic                       out_tlast,  // end_of_run
  output logic                       out_tuser   // end_of_frame
);

  sfsc_push_t  push;
  logic        q_full, q_pop, q_valid;
  sfsc_entry_t q_head;

  sfsc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .push      (push)
  );

  sfsc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head       (q_head)
  );

  sfsc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_valid),
    .head       (q_head),
    .pop        (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

`default_nettype wire

[hw/rtl/sfsc_front.sv]
// ----------------------------------------------------------------------------
// sfsc_front
// Accepts input beats, tracks the open frame and queues headers and payload.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sample_frame_serializer_crc16_macros.svh"

module sfsc_front import sfsc_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_TDATA_W-1:0] in_tdata,
  input  wire logic                  in_tuser,
  input  wire logic                  q_full,
  output sfsc_push_t                 push
);

  logic             frame_open_r, frame_open_nxt;
  logic [LEN_W-1:0] bytes_left_r, bytes_left_nxt;
  logic             accept;
  sfsc_entry_t      ent;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    ent.cmd     = in_tuser;
    ent.last    = (bytes_left_r == LEN_W'(1));
    ent.seq     = in_tdata[31:0];
    ent.ts      = in_tdata[95:32];
    ent.rssi    = in_tdata[103:96];
    ent.rate    = in_tdata[111:104];
    ent.channel = in_tdata[119:112];
    ent.flags   = in_tdata[127:120];
    ent.len     = in_tdata[136:128];
    ent.pbyte   = in_tdata[144:137];
  end

  always_comb begin
    frame_open_nxt = frame_open_r;
    bytes_left_nxt = bytes_left_r;
    push.valid     = 1'b0;
    push.entry     = ent;
    if (accept) begin
      if (in_tuser == CMD_HEADER) begin
        if (32'(ent.len) > MAX_PAYLOAD) begin
          // rejected header also abandons an open frame
          frame_open_nxt = 1'b0;
          bytes_left_nxt = '0;
        end else begin
          push.valid     = 1'b1;
          frame_open_nxt = (ent.len != '0);
          bytes_left_nxt = ent.len;
        end
      end else if (frame_open_r && bytes_left_r != '0) begin
        push.valid     = 1'b1;
        bytes_left_nxt = bytes_left_r - LEN_W'(1);
        frame_open_nxt = !ent.last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_open_r <= 1'b0;
      bytes_left_r <= '0;
    end else begin
      frame_open_r <= frame_open_nxt;
      bytes_left_r <= bytes_left_nxt;
    end
  end

  `SFSC_ASSERT_IMPL(a_open_has_bytes, clk, rst_n, frame_open_r, bytes_left_r != '0 && 32'(bytes_left_r) <= MAX_PAYLOAD, "open frame with bad byte count")

endmodule

`default_nettype wire

[hw/rtl/sfsc_queue.sv]
// ----------------------------------------------------------------------------
// sfsc_queue
// Small FIFO of classified items between the front and the serializer.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sample_frame_serializer_crc16_macros.svh"

module sfsc_queue import sfsc_pkg::*; #(
  parameter int unsigned DEPTH = 4  // 2 or more
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire sfsc_push_t push,
  output logic            full,
  input  wire logic       pop,
  output logic            head_valid,
  output sfsc_entry_t     head
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  sfsc_entry_t      mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full       = (count_r == CNT_W'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head       = mem[rd_ptr_r];
  assign do_push    = push.valid && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  `SFSC_ASSERT_IMPL(a_count_bound, clk, rst_n, 1'b1, count_r <= CNT_W'(DEPTH), "queue count beyond depth")

endmodule

`default_nettype wire

[hw/rtl/sfsc_back.sv]
// ----------------------------------------------------------------------------
// sfsc_back
// Serializes queued items into frame bytes, runs the CRC, drives the output.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sample_frame_serializer_crc16_macros.svh"

module sfsc_back import sfsc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        head_valid,
  input  wire sfsc_entry_t head,
  output logic             pop,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,
  output logic             out_tlast,
  output logic             out_tuser
);

  sfsc_state_t      st_r, st_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [15:0]      crc_r, crc_nxt;
  sfsc_entry_t      hdr_r;
  logic             out_valid_r;
  logic [7:0]       out_byte_r;
  logic             out_last_r, out_eof_r;
  logic             load, emit, e_last, e_eof;
  logic [7:0]       e_byte, hdr_byte;
  logic [15:0]      size;

  assign load       = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_eof_r;
  assign size       = FIXED_OVERHEAD + 16'(hdr_r.len);

  always_comb begin
    case (idx_r)
      5'd0:    hdr_byte = MAGIC_0;
      5'd1:    hdr_byte = MAGIC_1;
      5'd2:    hdr_byte = MAGIC_2;
      5'd3:    hdr_byte = MAGIC_3;
      5'd4:    hdr_byte = VERSION;
      5'd5:    hdr_byte = SAMPLE_KIND;
      5'd6:    hdr_byte = size[7:0];
      5'd7:    hdr_byte = size[15:8];
      5'd8:    hdr_byte = hdr_r.seq[7:0];
      5'd9:    hdr_byte = hdr_r.seq[15:8];
      5'd10:   hdr_byte = hdr_r.seq[23:16];
      5'd11:   hdr_byte = hdr_r.seq[31:24];
      5'd12:   hdr_byte = hdr_r.ts[7:0];
      5'd13:   hdr_byte = hdr_r.ts[15:8];
      5'd14:   hdr_byte = hdr_r.ts[23:16];
      5'd15:   hdr_byte = hdr_r.ts[31:24];
      5'd16:   hdr_byte = hdr_r.ts[39:32];
      5'd17:   hdr_byte = hdr_r.ts[47:40];
      5'd18:   hdr_byte = hdr_r.ts[55:48];
      5'd19:   hdr_byte = hdr_r.ts[63:56];
      5'd20:   hdr_byte = hdr_r.rssi;
      5'd21:   hdr_byte = hdr_r.rate;
      5'd22:   hdr_byte = hdr_r.channel;
      5'd23:   hdr_byte = hdr_r.flags;
      5'd24:   hdr_byte = hdr_r.len[7:0];
      5'd25:   hdr_byte = {7'b0, hdr_r.len[8]};
      default: hdr_byte = 8'h00;
    endcase
  end

  always_comb begin
    st_nxt  = st_r;
    idx_nxt = idx_r;
    crc_nxt = crc_r;
    pop     = 1'b0;
    emit    = 1'b0;
    e_byte  = 8'h00;
    e_last  = 1'b0;
    e_eof   = 1'b0;
    case (st_r)
      ST_IDLE: begin
        if (head_valid && load) begin
          pop  = 1'b1;
          emit = 1'b1;
          if (head.cmd == CMD_HEADER) begin
            // magic byte goes out now, CRC restarts (magic is not covered)
            e_byte  = MAGIC_0;
            crc_nxt = CRC_INIT;
            idx_nxt = IDX_W'(1);
            st_nxt  = ST_HEAD;
          end else begin
            e_byte  = head.pbyte;
            e_last  = !head.last;
            crc_nxt = crc_feed(crc_r, head.pbyte);
            if (head.last) begin
              st_nxt = ST_CRC_LO;
            end
          end
        end
      end
      ST_HEAD: begin
        if (load) begin
          emit   = 1'b1;
          e_byte = hdr_byte;
          if (idx_r >= IDX_CRC_FIRST) begin
            crc_nxt = crc_feed(crc_r, hdr_byte);
          end
          if (idx_r == IDX_HEAD_LAST) begin
            e_last = (hdr_r.len != '0);
            st_nxt = (hdr_r.len == '0) ? ST_CRC_LO : ST_IDLE;
          end else begin
            idx_nxt = idx_r + IDX_W'(1);
          end
        end
      end
      ST_CRC_LO: begin
        if (load) begin
          emit   = 1'b1;
          e_byte = crc_r[7:0];
          st_nxt = ST_CRC_HI;
        end
      end
      ST_CRC_HI: begin
        if (load) begin
          emit    = 1'b1;
          e_byte  = crc_r[15:8];
          e_last  = 1'b1;
          e_eof   = 1'b1;
          crc_nxt = CRC_INIT;
          st_nxt  = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      idx_r       <= '0;
      crc_r       <= CRC_INIT;
      out_valid_r <= 1'b0;
    end else begin
      st_r  <= st_nxt;
      idx_r <= idx_nxt;
      crc_r <= crc_nxt;
      if (load) begin
        out_valid_r <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && emit) begin
      out_byte_r <= e_byte;
      out_last_r <= e_last;
      out_eof_r  <= e_eof;
    end
    if (pop && head.cmd == CMD_HEADER) begin
      hdr_r <= head;
    end
  end

  `SFSC_ASSERT_IMPL(a_eof_ends_run, clk, rst_n, out_tvalid && out_tuser, out_tlast, "frame end without run end")
  `SFSC_ASSERT_NEXT(a_crc_lo_then_hi, clk, rst_n, st_r == ST_CRC_LO && load, st_r == ST_CRC_HI && out_tvalid && !out_tlast, "CRC low byte not followed by high byte")

endmodule

`default_nettype wire

[tb/tb_sample_frame_serializer_crc16.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sample_frame_serializer_crc16
// Streams header and payload beats into the serializer and predicts every
// frame byte, end-of-run flag and end-of-frame flag, CRC trailer included.
// Covers empty, maximum-length-header, abandoned, oversized and stray cases, then random
// frames with random gaps on the input and random backpressure on the output.
// ----------------------------------------------------------------------------
module tb_sample_frame_serializer_crc16 import sfsc_pkg::*; ();

  localparam int HEAD_LEN    = 26;
  localparam int REPORT_MAX  = 10;
  localparam int TOTAL_ITEMS = 150;

  // packed low field in the low bits, matches the in_tdata layout
  typedef struct packed {
    logic [7:0]        pbyte;
    logic [LEN_W-1:0]  len;
    logic [7:0]        flags;
    logic [7:0]        channel;
    logic [7:0]        rate;
    logic signed [7:0] rssi;
    logic [63:0]       ts;
    logic [31:0]       seq;
  } sample_item_t;

  typedef struct packed {
    logic [7:0] data;
    logic       run_end;
    logic       frame_end;
  } frame_byte_t;

  class frame_byte_scoreboard;
    frame_byte_t expected_bytes[$];
    logic [15:0] crc_run;
    int unsigned payload_left;
    bit          in_frame;
    int unsigned errors;
    int unsigned bytes_checked;
    int unsigned frames_closed;

    function new();
      crc_run       = CRC_INIT;
      payload_left  = 0;
      in_frame      = 1'b0;
      errors        = 0;
      bytes_checked = 0;
      frames_closed = 0;
    endfunction

    // bit-serial form of CCITT, msb first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] d);
      logic [15:0] c;
      logic        fb;
      c = crc;
      for (int i = 7; i >= 0; i--) begin
        fb = c[15] ^ d[i];
        c  = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
      end
      return c;
    endfunction

    function void close_frame();
      expected_bytes.push_back('{crc_run[7:0], 1'b0, 1'b0});
      expected_bytes.push_back('{crc_run[15:8], 1'b1, 1'b1});
      in_frame     = 1'b0;
      payload_left = 0;
      crc_run      = CRC_INIT;
    endfunction

    // returns how many frame bytes this beat produces
    function int predict_frame_bytes(input logic cmd, input sample_item_t it);
      logic [7:0]  hdr [HEAD_LEN];
      logic [15:0] size;
      if (cmd == CMD_HEADER) begin
        if (it.len > MAX_PAYLOAD) begin
          in_frame     = 1'b0;
          payload_left = 0;
          crc_run      = CRC_INIT;
          return 0;
        end
        size   = FIXED_OVERHEAD + {7'd0, it.len};
        hdr[0] = MAGIC_0;
        hdr[1] = MAGIC_1;
        hdr[2] = MAGIC_2;
        hdr[3] = MAGIC_3;
        hdr[4] = VERSION;
        hdr[5] = SAMPLE_KIND;
        hdr[6] = size[7:0];
        hdr[7] = size[15:8];
        for (int i = 0; i < 4; i++) hdr[8 + i] = it.seq[8*i +: 8];
        for (int i = 0; i < 8; i++) hdr[12 + i] = it.ts[8*i +: 8];
        hdr[20] = it.rssi;
        hdr[21] = it.rate;
        hdr[22] = it.channel;
        hdr[23] = it.flags;
        hdr[24] = it.len[7:0];
        hdr[25] = {7'd0, it.len[8]};
        // magic stays outside the CRC
        crc_run = CRC_INIT;
        for (int i = 4; i < HEAD_LEN; i++) crc_run = crc_byte(crc_run, hdr[i]);
        for (int i = 0; i < HEAD_LEN; i++)
          expected_bytes.push_back('{hdr[i], (it.len != 0 && i == HEAD_LEN - 1), 1'b0});
        if (it.len == 0) begin
          close_frame();
          return HEAD_LEN + 2;
        end
        in_frame     = 1'b1;
        payload_left = 32'(it.len);
        return HEAD_LEN;
      end
      if (!in_frame || payload_left == 0) return 0;
      crc_run = crc_byte(crc_run, it.pbyte);
      payload_left--;
      if (payload_left != 0) begin
        expected_bytes.push_back('{it.pbyte, 1'b1, 1'b0});
        return 1;
      end
      expected_bytes.push_back('{it.pbyte, 1'b0, 1'b0});
      close_frame();
      return 3;
    endfunction

    function void check_byte(input logic [7:0] data, input logic run_end, input logic frame_end);
      frame_byte_t want;
      if (expected_bytes.size() == 0) begin
        errors++;
        if (errors <= REPORT_MAX)
          $display("%0t: unexpected beat data=%02h last=%b user=%b",
                   $time, data, run_end, frame_end);
        return;
      end
      want = expected_bytes.pop_front();
      bytes_checked++;
      if (frame_end) frames_closed++;
      if (data !== want.data || run_end !== want.run_end || frame_end !== want.frame_end) begin
        errors++;
        if (errors <= REPORT_MAX)
          $display("%0t: beat %0d mismatch: expected data=%02h last=%b user=%b, got %02h %b %b",
                   $time, bytes_checked, want.data, want.run_end, want.frame_end,
                   data, run_end, frame_end);
      end
    endfunction

    function int pending();
      return expected_bytes.size();
    endfunction
  endclass

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_TDATA_W-1:0] in_tdata   = '0;
  logic                  in_tuser   = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [7:0]            out_tdata;
  logic                  out_tlast;
  logic                  out_tuser;

  frame_byte_scoreboard sb = new();
  bit          steady      = 1'b0;
  int unsigned headers_cnt = 0;
  int unsigned payload_cnt = 0;
  int unsigned dropped_cnt = 0;

  sample_frame_serializer_crc16 u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_tready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 14);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_byte(out_tdata, out_tlast, out_tuser);
  end

  function automatic sample_item_t rand_item();
    sample_item_t it;
    it.seq     = $urandom;
    it.ts      = {$urandom, $urandom};
    it.rssi    = 8'($urandom);
    it.rate    = 8'($urandom);
    it.channel = 8'($urandom);
    it.flags   = 8'($urandom);
    it.len     = LEN_W'($urandom);
    it.pbyte   = 8'($urandom);
    return it;
  endfunction

  task automatic send_beat(input logic cmd, input sample_item_t it);
    int n;
    while (!steady && $urandom_range(0, 99) < 14) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {7'd0, it};
    do @(posedge clk); while (!in_tready);
    n = sb.predict_frame_bytes(cmd, it);
    if (cmd == CMD_HEADER) headers_cnt++;
    else payload_cnt++;
    if (n == 0) dropped_cnt++;
  endtask

  task automatic send_header(input logic [LEN_W-1:0] len);
    sample_item_t it;
    it     = rand_item();
    it.len = len;
    send_beat(CMD_HEADER, it);
  endtask

  task automatic send_payload(input int count);
    repeat (count) send_beat(CMD_PAYLOAD, rand_item());
  endtask

  initial begin
    sample_item_t it;
    int           sel;
    int           len;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // stray payload with nothing open
    send_payload(1);
    // empty frames, all fields low then all fields but the length high
    it = '0;
    send_beat(CMD_HEADER, it);
    it     = '1;
    it.len = '0;
    send_beat(CMD_HEADER, it);
    // most negative rssi, payload byte extremes
    it         = rand_item();
    it.rssi    = -8'sd128;
    it.len     = LEN_W'(2);
    send_beat(CMD_HEADER, it);
    it.pbyte = 8'h00;
    send_beat(CMD_PAYLOAD, it);
    it.pbyte = 8'hFF;
    send_beat(CMD_PAYLOAD, it);
    // max length opened, then abandoned by a new header
    send_header(LEN_W'(MAX_PAYLOAD));
    send_payload(2);
    send_header(LEN_W'(3));
    send_payload(3);
    // oversized header kills the open frame; the next payload is stray
    send_header(LEN_W'(4));
    send_payload(1);
    send_header(LEN_W'(MAX_PAYLOAD + 1));
    send_payload(1);
    send_header('1);
    send_header(LEN_W'(1));
    send_payload(1);

    while (headers_cnt + payload_cnt < TOTAL_ITEMS) begin
      steady = (headers_cnt + payload_cnt >= 70 && headers_cnt + payload_cnt < 110);
      sel    = $urandom_range(0, 99);
      if (sel < 70) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
        send_header(LEN_W'(len));
        send_payload(len);
      end else if (sel < 80) begin
        // truncated frame (complete when len is 5 and five bytes follow), left for the next header to abandon
        len = $urandom_range(1, MAX_PAYLOAD);
        send_header(LEN_W'(len));
        send_payload($urandom_range(0, (len < 5) ? len - 1 : 5));
      end else if (sel < 90) begin
        send_payload(1);
      end else begin
        send_header(LEN_W'($urandom_range(MAX_PAYLOAD + 1, (1 << LEN_W) - 1)));
      end
    end
    steady = 1'b0;
    in_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    $display("Sent %0d headers and %0d payload beats, %0d of them dropped",
             headers_cnt, payload_cnt, dropped_cnt);
    $display("Checked %0d output beats across %0d closed frames, %0d mismatches",
             sb.bytes_checked, sb.frames_closed, sb.errors);
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #400_000;
    $display("Timeout with %0d beats still expected", sb.pending());
    $display("Simulation FAILED");
    $finish;
  end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/sfsc_pkg.sv
hw/rtl/sfsc_front.sv
hw/rtl/sfsc_queue.sv
hw/rtl/sfsc_back.sv
hw/rtl/sample_frame_serializer_crc16.sv
tb/tb_sample_frame_serializer_crc16.sv
